// ----- hdl/xbg_pkg.sv -----
// shared types, constants and helpers of the xorshift byte generator
package xbg_pkg;

   localparam logic [63:0] SEED       = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MULTIPLIER = 64'h2545_F491_4F6C_DD1D;

   localparam int LEN_W       = 7;
   localparam int QUEUE_DEPTH = 2;

   localparam logic OP_READ   = 1'b0;
   localparam logic OP_RESEED = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] request_length;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       status;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_READ    = 2'd0,
      CMD_RESEED  = 2'd1,
      CMD_INVALID = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [LEN_W-1:0] length;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic    not_empty;
      cmd_type cmd;
   } head_type;

   function automatic logic [63:0] xorshift(input logic [63:0] x);
      logic [63:0] t;
      t = x ^ (x >> 12);
      t = t ^ (t << 25);
      t = t ^ (t >> 27);
      return t;
   endfunction

endpackage

// ----- hdl/xbg_front.sv -----
// request front end: accepts beats and classifies them into commands
module xbg_front import xbg_pkg::*; #(
   parameter int MAX_BYTES = 64
) (
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  logic     queue_full,
   output push_type push
);

   logic len_bad;

   assign len_bad = (req_data.request_length == 8'd0) ||
                    (req_data.request_length > 8'(MAX_BYTES));

   assign req_stall  = queue_full;
   assign push.valid = req_valid && !queue_full;

   always_comb begin
      push.cmd.length = LEN_W'(req_data.request_length);
      if (req_data.op == OP_RESEED) begin
         push.cmd.kind = CMD_RESEED;
      end else if (len_bad) begin
         push.cmd.kind = CMD_INVALID;
      end else begin
         push.cmd.kind = CMD_READ;
      end
   end

endmodule

// ----- hdl/xbg_queue.sv -----
// small command queue between front end and back end
module xbg_queue import xbg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     full,
   input  logic     pop,
   output head_type head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full           = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head.not_empty = (count_ff != '0);
   assign head.cmd       = entry_ff[rd_ptr_ff];
   assign do_push        = push.valid && !full;
   assign do_pop         = pop && head.not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// ----- hdl/xbg_back.sv -----
// command back end: generator state, shared multiplier and byte output
module xbg_back import xbg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  head_type head,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MIX  = 6'b000010,
      ST_MUL0 = 6'b000100,
      ST_MUL1 = 6'b001000,
      ST_MUL2 = 6'b010000,
      ST_EMIT = 6'b100000
   } fsm_type;

   fsm_type          fsm_ff, fsm_in;
   logic [63:0]      gen_ff, gen_in;
   logic [63:0]      prod_ff, prod_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [2:0]       pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             out_load;
   logic [31:0]      mul_a, mul_b;
   logic [63:0]      mul_p;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign mul_a = (fsm_ff == ST_MUL2) ? gen_ff[63:32] : gen_ff[31:0];
   assign mul_b = (fsm_ff == ST_MUL1) ? MULTIPLIER[63:32] : MULTIPLIER[31:0];
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      fsm_in       = fsm_ff;
      gen_in       = gen_ff;
      prod_in      = prod_ff;
      remain_in    = remain_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      case (fsm_ff)
         ST_IDLE: begin
            if (head.not_empty) begin
               case (head.cmd.kind)
                  CMD_READ: begin
                     pop       = 1'b1;
                     remain_in = head.cmd.length;
                     pos_in    = '0;
                     fsm_in    = ST_MIX;
                  end
                  CMD_RESEED: begin
                     if (out_load) begin
                        pop          = 1'b1;
                        gen_in       = SEED;
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{byte_out: 8'd0, status: STATUS_OK, last: 1'b1};
                     end
                  end
                  default: begin
                     if (out_load) begin
                        pop          = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{byte_out: 8'd0, status: STATUS_INVALID, last: 1'b1};
                     end
                  end
               endcase
            end
         end
         ST_MIX: begin
            gen_in = xorshift(gen_ff);
            fsm_in = ST_MUL0;
         end
         ST_MUL0: begin
            prod_in = mul_p;
            fsm_in  = ST_MUL1;
         end
         ST_MUL1: begin
            prod_in[63:32] = prod_ff[63:32] + mul_p[31:0];
            fsm_in         = ST_MUL2;
         end
         ST_MUL2: begin
            prod_in[63:32] = prod_ff[63:32] + mul_p[31:0];
            fsm_in         = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in    = 1'b1;
               rsp_in.byte_out = prod_ff[{pos_ff, 3'b000} +: 8];
               rsp_in.status   = STATUS_OK;
               rsp_in.last     = (remain_ff == LEN_W'(1));
               remain_in       = remain_ff - 1'b1;
               pos_in          = pos_ff + 1'b1;
               if (remain_ff == LEN_W'(1)) begin
                  fsm_in = ST_IDLE;
               end else if (pos_ff == 3'd7) begin
                  fsm_in = ST_MIX;
               end
            end
         end
         default: begin
            fsm_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_IDLE;
         gen_ff       <= SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      remain_ff <= remain_in;
      pos_ff    <= pos_in;
      rsp_ff    <= rsp_in;
   end

endmodule

// ----- hdl/xorshift_byte_generator.sv -----
// top level of the xorshift64* pseudo-random byte generator
//
// Request channel (req_): a beat carries op and request_length. A reseed
// beat restores the generator to its fixed seed and answers with one ok
// beat. A read beat asks for 1 to MAX_BYTES bytes; any other length gives
// one beat with status set to invalid and the state untouched.
// Response channel (rsp_): one beat per byte, least significant byte of
// each generated word first, with last on the final beat of a request.
// Status-only beats carry a zero byte and last set.
// Requests are classified on entry and queued (two deep), so the request
// side keeps taking beats while the back end works or the receiver stalls.
// Path: a status-only beat passes through the queue entry and the
// response register; the first byte of a read passes through the queue
// entry, the back end states IDLE, MIX, MUL0, MUL1, MUL2 and EMIT, and
// the response register. Each word of eight bytes is mixed and then
// multiplied in the shared 32x32 multiplier before its bytes are emitted,
// and the back end takes no new command until a read has ended.
// Reset (synchronous) empties the queue, drops any pending output beat and
// loads the seed. A stalled response beat holds until taken; the back end
// then waits, and the request side stalls once the queue is full.
module xorshift_byte_generator import xbg_pkg::*; #(
   parameter int MAX_BYTES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   xbg_front #(
      .MAX_BYTES (MAX_BYTES)
   ) u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push)
   );

   xbg_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   xbg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_invalid_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_INVALID |-> rsp_data.last)
      else $error("invalid status beat without last");

   a_invalid_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_INVALID |-> rsp_data.byte_out == 8'd0)
      else $error("invalid status beat with nonzero byte");

   a_reset_clears_output: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

// ----- test/xorshift_byte_generator_test.sv -----
// self-checking testbench of the xorshift byte generator with bursty requests and stalls
module xorshift_byte_generator_test import xbg_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          READ_MAX    = 64;
   localparam logic [63:0] GOLDEN_SEED = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] STAR_MULT   = 64'h2545_F491_4F6C_DD1D;

   typedef struct {
      req_type data;
      bit      drain;
   } queued_req_type;

   typedef enum int {
      FLOW_FREE,
      FLOW_RANDOM,
      FLOW_PERIODIC,
      FLOW_SPARSE
   } flow_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   queued_req_type pending_reqs[$];
   rsp_type        expected_beats[$];
   logic [63:0]    gen_state = GOLDEN_SEED;

   bit       req_taken = 1'b0;
   int       burst_left = 0;
   int       gap_left = 0;
   int       hold_left = 0;
   bit       holdoff_done = 1'b0;
   flow_type stall_mode = FLOW_FREE;
   int       mode_left = 0;
   int       stall_phase = 0;

   int requests_taken = 0;
   int reseeds = 0;
   int rejects = 0;
   int beats_seen = 0;
   int mismatches = 0;

   xorshift_byte_generator #(
      .MAX_BYTES(READ_MAX)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at beat %0d: %s", beats_seen, msg);
      mismatches++;
   endtask

   task automatic add_req(input logic op, input logic [7:0] length, input bit drain = 1'b0);
      queued_req_type item;
      item.data.op = op;
      item.data.request_length = length;
      item.drain = drain;
      pending_reqs.push_back(item);
   endtask

   function automatic void predict_bytes(input req_type r);
      logic [63:0] word;
      int          n;
      word = '0;
      n = r.request_length;
      if (r.op == OP_RESEED) begin
         gen_state = GOLDEN_SEED;
         expected_beats.push_back(rsp_type'{byte_out: 8'h00, status: STATUS_OK, last: 1'b1});
         reseeds++;
      end else if (n == 0 || n > READ_MAX) begin
         expected_beats.push_back(
            rsp_type'{byte_out: 8'h00, status: STATUS_INVALID, last: 1'b1});
         rejects++;
      end else begin
         for (int i = 0; i < n; i++) begin
            if (i % 8 == 0) begin
               gen_state = gen_state ^ (gen_state >> 12);
               gen_state = gen_state ^ (gen_state << 25);
               gen_state = gen_state ^ (gen_state >> 27);
               word = gen_state * STAR_MULT;
            end
            expected_beats.push_back(rsp_type'{byte_out: word[8 * (i % 8) +: 8],
                                               status: STATUS_OK,
                                               last: (i == n - 1)});
         end
      end
   endfunction

   always @(posedge clock) begin : check_and_predict
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat byte %02h status %0b last %0b",
                                      rsp_data.byte_out, rsp_data.status, rsp_data.last));
         end else begin
            want = expected_beats.pop_front();
            if (rsp_data.byte_out !== want.byte_out)
               report_mismatch($sformatf("byte_out %02h, want %02h",
                                         rsp_data.byte_out, want.byte_out));
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %0b, want %0b", rsp_data.status, want.status));
            if (rsp_data.last !== want.last)
               report_mismatch($sformatf("last %0b, want %0b", rsp_data.last, want.last));
         end
         beats_seen++;
      end
      if (!reset && req_valid && !req_stall) begin
         predict_bytes(req_data);
         void'(pending_reqs.pop_front());
         req_taken = 1'b1;
         requests_taken++;
      end
   end

   always @(negedge clock) begin : drive_requests
      logic next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() != 0 &&
                      !(pending_reqs[0].drain && expected_beats.size() != 0)) begin
            next_valid = 1'b1;
            req_data <= pending_reqs[0].data;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
      req_valid <= next_valid;
   end

   always @(negedge clock) begin : drive_stall
      logic next_stall;
      next_stall = 1'b0;
      if (hold_left > 0) begin
         hold_left--;
         next_stall = 1'b1;
      end else if (!holdoff_done && requests_taken >= 40) begin
         // long hold-off so the request queue fills and stalls the sender
         holdoff_done = 1'b1;
         hold_left = 299;
         next_stall = 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = flow_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            FLOW_FREE:     next_stall = 1'b0;
            FLOW_RANDOM:   next_stall = 1'($urandom_range(0, 1));
            FLOW_PERIODIC: next_stall = (stall_phase % 4 == 3);
            default:       next_stall = ($urandom_range(0, 7) == 0);
         endcase
         stall_phase++;
      end
      rsp_stall <= next_stall;
   end

   initial begin : stimulus
      int sel;
      add_req(OP_READ, 8'd1);
      add_req(OP_READ, 8'd8);
      add_req(OP_READ, 8'd9);
      add_req(OP_READ, 8'd64);
      add_req(OP_READ, 8'd65);
      add_req(OP_READ, 8'd0);
      add_req(OP_READ, 8'd255);
      add_req(OP_READ, 8'd128);
      add_req(OP_READ, 8'd7);
      add_req(OP_READ, 8'd63);
      add_req(OP_RESEED, 8'd255);
      add_req(OP_READ, 8'd16);
      add_req(OP_RESEED, 8'd0);
      add_req(OP_READ, 8'd64);
      add_req(OP_READ, 8'd17, 1'b1);
      add_req(OP_RESEED, 8'hAA);
      add_req(OP_READ, 8'd2);
      add_req(OP_READ, 8'h55);
      add_req(OP_READ, 8'd42);
      for (int k = 0; k < 241; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 8)
            add_req(OP_RESEED, 8'($urandom_range(0, 255)), k % 40 == 39);
         else if (sel < 16)
            add_req(OP_READ,
                    ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(65, 255)),
                    k % 40 == 39);
         else if (sel < 70)
            add_req(OP_READ, 8'($urandom_range(1, 16)), k % 40 == 39);
         else
            add_req(OP_READ, 8'($urandom_range(17, READ_MAX)), k % 40 == 39);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_reqs.size() != 0 || expected_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d requests (%0d reseeds, %0d rejected lengths), %0d beats checked",
               requests_taken, reseeds, rejects, beats_seen);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin : watchdog
      #8ms;
      $display("timeout with %0d requests pending, %0d beats outstanding",
               pending_reqs.size(), expected_beats.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
